/* hw/rtl/ipw_pkg.sv */
// Shared types and constants of the injector pulse width calculator.
package ipw_pkg;

  localparam int unsigned BASE_W = 20;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned LAG_W = 16;
  localparam int unsigned CYL_W = 4;
  localparam int unsigned STEP_MAX = 7;
  localparam int unsigned STEP_IDX_W = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PADDR_W = 5;

  typedef enum logic [1:0] {
    MODE_SIMULTANEOUS = 2'd0,
    MODE_SINGLE_POINT = 2'd1,
    MODE_BATCH        = 2'd2,
    MODE_SEQUENTIAL   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_FUEL   = 2'd1,
    ST_NO_CYL      = 2'd2,
    ST_LAG_INVALID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_CYL         = 3'd1,
    REG_GLOBAL      = 3'd2,
    REG_CRANK_RUN   = 3'd3,
    REG_CRANK_BASE  = 3'd4,
    REG_LAUNCH_EN   = 3'd5,
    REG_LAUNCH_GAIN = 3'd6
  } reg_idx_t;

  typedef struct packed {
    mode_t              mode;
    logic [CYL_W-1:0]   cyl;
    logic [COEF_W-1:0]  global_corr;
    logic               crank_run;
    logic [BASE_W-1:0]  crank_base;
    logic               launch_en;
    logic [COEF_W-1:0]  launch_gain;
  } cfg_t;

  // One classified request: the starting fuel amount and the ordered list of
  // scaling steps the back end walks through.
  typedef struct packed {
    logic [BASE_W-1:0]                 base;
    logic                              cranking;
    logic                              no_cyl;
    logic                              lag_ok;
    logic [LAG_W-1:0]                  lag;
    logic [COEF_W-1:0]                 global_corr;
    logic [CYL_W-1:0]                  ninj;
    logic [STEP_MAX-1:0][COEF_W-1:0]   coef;
    logic [STEP_MAX-1:0]               is_cyl;
    logic [STEP_IDX_W-1:0]             nsteps;
    logic [STEP_IDX_W-1:0]             zchk;
  } job_t;

endpackage

/* hw/rtl/ipw_in_if.sv */
// Request channel interface of the injector pulse width calculator.
interface ipw_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] base_fuel_us;
  logic        is_cranking;
  logic [15:0] iat_coef;
  logic [15:0] clt_coef;
  logic [15:0] post_crank_coef;
  logic [15:0] pid_coef;
  logic        launch_active;
  logic [15:0] crank_duration_coef;
  logic [15:0] crank_clt_coef;
  logic [15:0] cutoff_coef;
  logic [15:0] injector_lag_us;
  logic        lag_valid;

  modport source (
    output valid, base_fuel_us, is_cranking, iat_coef, clt_coef, post_crank_coef,
           pid_coef, launch_active, crank_duration_coef, crank_clt_coef, cutoff_coef,
           injector_lag_us, lag_valid,
    input  ready
  );

  modport sink (
    input  valid, base_fuel_us, is_cranking, iat_coef, clt_coef, post_crank_coef,
           pid_coef, launch_active, crank_duration_coef, crank_clt_coef, cutoff_coef,
           injector_lag_us, lag_valid,
    output ready
  );
endinterface

/* hw/rtl/ipw_out_if.sv */
// Result channel interface of the injector pulse width calculator.
interface ipw_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] pulse_us;
  logic [1:0]  status;
  logic        crank_fuel_zero;
  logic        saturated;

  modport source (
    output valid, pulse_us, status, crank_fuel_zero, saturated,
    input  ready
  );

  modport sink (
    input  valid, pulse_us, status, crank_fuel_zero, saturated,
    output ready
  );
endinterface

/* hw/rtl/ipw_regs.sv */
// APB configuration registers of the injector pulse width calculator.
module ipw_regs
  import ipw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_SEQUENTIAL;
      cfg.cyl         <= CYL_W'(4);
      cfg.global_corr <= COEF_W'(4096);
      cfg.crank_run   <= 1'b0;
      cfg.crank_base  <= BASE_W'(6000);
      cfg.launch_en   <= 1'b0;
      cfg.launch_gain <= COEF_W'(4096);
    end else if (wr_en) begin
      case (paddr[PADDR_W-1:2])
        REG_MODE:        cfg.mode        <= mode_t'(pwdata[1:0]);
        REG_CYL:         cfg.cyl         <= pwdata[CYL_W-1:0];
        REG_GLOBAL:      cfg.global_corr <= pwdata[COEF_W-1:0];
        REG_CRANK_RUN:   cfg.crank_run   <= pwdata[0];
        REG_CRANK_BASE:  cfg.crank_base  <= pwdata[BASE_W-1:0];
        REG_LAUNCH_EN:   cfg.launch_en   <= pwdata[0];
        REG_LAUNCH_GAIN: cfg.launch_gain <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[PADDR_W-1:2])
      REG_MODE:        prdata = 32'(cfg.mode);
      REG_CYL:         prdata = 32'(cfg.cyl);
      REG_GLOBAL:      prdata = 32'(cfg.global_corr);
      REG_CRANK_RUN:   prdata = 32'(cfg.crank_run);
      REG_CRANK_BASE:  prdata = 32'(cfg.crank_base);
      REG_LAUNCH_EN:   prdata = 32'(cfg.launch_en);
      REG_LAUNCH_GAIN: prdata = 32'(cfg.launch_gain);
      default:         prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/ipw_front.sv */
// Front end: accepts requests and turns each into a list of scaling steps.
module ipw_front
  import ipw_pkg::*;
#(
  parameter int unsigned MAX_CYLINDERS = 12
) (
  ipw_in_if.sink req,
  input  cfg_t   cfg,
  input  logic   q_ready,
  output logic   push,
  output job_t   job
);

  logic [CYL_W-1:0]      cyl_eff;
  logic [STEP_IDX_W-1:0] k;

  assign push = req.valid;
  assign req.ready = q_ready;

  // Cylinder counts above the supported maximum are treated as the maximum.
  assign cyl_eff = ({1'b0, cfg.cyl} > (CYL_W + 1)'(MAX_CYLINDERS)) ?
                   CYL_W'(MAX_CYLINDERS) : cfg.cyl;

  always_comb begin
    job = '0;
    k = '0;
    job.cranking    = req.is_cranking;
    job.lag_ok      = req.lag_valid;
    job.lag         = req.injector_lag_us;
    job.global_corr = cfg.global_corr;

    case (cfg.mode)
      MODE_SIMULTANEOUS, MODE_SINGLE_POINT: job.ninj = cyl_eff;
      MODE_BATCH:                           job.ninj = CYL_W'(2);
      default:                              job.ninj = CYL_W'(1);
    endcase
    job.no_cyl = (job.ninj == '0);

    if (req.is_cranking) begin
      job.base = cfg.crank_run ? req.base_fuel_us : cfg.crank_base;
      job.coef[0] = req.crank_duration_coef;
      job.coef[1] = req.crank_clt_coef;
      k = STEP_IDX_W'(2);
    end else begin
      job.base = req.base_fuel_us;
      job.coef[0] = req.iat_coef;
      job.coef[1] = req.clt_coef;
      job.coef[2] = req.post_crank_coef;
      if (req.launch_active && cfg.launch_en) begin
        job.coef[3] = cfg.launch_gain;
        job.coef[4] = req.pid_coef;
        k = STEP_IDX_W'(5);
      end else begin
        job.coef[3] = req.pid_coef;
        k = STEP_IDX_W'(4);
      end
    end

    // The cranking zero test looks at the amount before the step at index zchk.
    job.zchk = k;
    if (cfg.mode == MODE_SINGLE_POINT) begin
      job.coef[k] = COEF_W'(cyl_eff);
      job.is_cyl[k] = 1'b1;
      k = k + STEP_IDX_W'(1);
    end
    job.coef[k] = req.cutoff_coef;
    job.nsteps = k + STEP_IDX_W'(1);
  end

endmodule

/* hw/rtl/ipw_queue.sv */
// Two-entry queue that carries classified requests from front to back.
module ipw_queue
  import ipw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count exceeds its depth");

  a_pop_changes_count: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - CNT_W'(1)))
    else $error("queue fill count did not drop after a pop");

endmodule

/* hw/rtl/ipw_back.sv */
// Back end: walks the scaling steps one at a time, divides, corrects, adds lag.
module ipw_back
  import ipw_pkg::*;
#(
  parameter int unsigned TIME_BITS      = 20,
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  job_t q_job,
  output logic q_pop,
  ipw_out_if.source rsp
);

  localparam int unsigned TB    = TIME_BITS;
  localparam int unsigned AW    = TIME_BITS + COEF_W;
  localparam int unsigned CW    = TIME_BITS + CYL_W;
  localparam int unsigned CNT_W = $clog2(TIME_BITS);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_CHK,
    S_DIV,
    S_GLOB,
    S_LAG,
    S_DONE
  } state_t;

  state_t                state;
  job_t                  j;
  logic [AW-1:0]         acc;
  logic [STEP_IDX_W-1:0] idx;
  logic                  sat;
  logic                  cz;
  logic [TB-1:0]         quo;
  logic [CYL_W-1:0]      rem;
  logic [CNT_W-1:0]      cnt;
  logic [TB-1:0]         pulse;
  status_t               status;

  logic                  o_valid;
  logic [19:0]           o_pulse;
  status_t               o_status;
  logic                  o_cz;
  logic                  o_sat;

  logic [AW-1:0]         base_ext;
  logic                  base_over;
  logic [TB-1:0]         base_clip;
  logic [AW-1:0]         acc_sh;
  logic                  ovf;
  logic [TB-1:0]         fuel_cur;
  logic [AW-1:0]         mul_prod;
  logic [CW-1:0]         cyl_prod;
  logic [TB-1:0]         cyl_clip;
  logic                  cyl_over;
  logic [CYL_W:0]        trial;
  logic                  trial_ge;
  logic [CYL_W:0]        trial_diff;
  logic [AW-1:0]         glob_prod;
  logic [TB:0]           lag_sum;
  logic [TB+19:0]        pulse_wide;

  // Starting amount, clipped to the time range.
  assign base_ext  = AW'(q_job.base);
  assign base_over = base_ext > AW'(TIME_MAX);
  assign base_clip = base_over ? TIME_MAX : base_ext[TB-1:0];

  // The accumulator holds the last product before its fraction shift.
  assign acc_sh   = acc >> COEF_FRAC_BITS;
  assign ovf      = acc_sh > AW'(TIME_MAX);
  assign fuel_cur = ovf ? TIME_MAX : acc_sh[TB-1:0];

  assign mul_prod = AW'(fuel_cur) * AW'(j.coef[idx]);
  assign cyl_prod = CW'(fuel_cur) * CW'(j.coef[idx][CYL_W-1:0]);
  assign cyl_over = cyl_prod > CW'(TIME_MAX);
  assign cyl_clip = cyl_over ? TIME_MAX : cyl_prod[TB-1:0];

  // One restoring division bit per cycle by the injection count.
  assign trial      = {rem, quo[TB-1]};
  assign trial_ge   = trial >= {1'b0, j.ninj};
  assign trial_diff = trial - {1'b0, j.ninj};

  assign glob_prod  = AW'(quo) * AW'(j.global_corr);
  assign lag_sum    = (TB + 1)'(fuel_cur) + (TB + 1)'(j.lag);
  assign pulse_wide = {20'b0, pulse};

  assign q_pop               = (state == S_IDLE);
  assign rsp.valid           = o_valid;
  assign rsp.pulse_us        = o_pulse;
  assign rsp.status          = o_status;
  assign rsp.crank_fuel_zero = o_cz;
  assign rsp.saturated       = o_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      // The result register empties on its handshake unless the finish state
      // refills it in the same cycle.
      if (o_valid && rsp.ready && (state != S_DONE)) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            j     <= q_job;
            cz    <= 1'b0;
            idx   <= '0;
            pulse <= '0;
            acc   <= AW'(base_clip) << COEF_FRAC_BITS;
            if (q_job.no_cyl) begin
              sat    <= 1'b0;
              status <= ST_NO_CYL;
              state  <= S_DONE;
            end else begin
              sat   <= base_over;
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (j.cranking && (idx == j.zchk) && (fuel_cur == '0)) begin
            cz <= 1'b1;
          end
          if (j.is_cyl[idx]) begin
            sat <= sat | ovf | cyl_over;
            acc <= AW'(cyl_clip) << COEF_FRAC_BITS;
          end else begin
            sat <= sat | ovf;
            acc <= mul_prod;
          end
          idx <= idx + STEP_IDX_W'(1);
          if (idx == j.nsteps - STEP_IDX_W'(1)) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          sat <= sat | ovf;
          if (fuel_cur == '0) begin
            status <= ST_ZERO_FUEL;
            state  <= S_DONE;
          end else if (!j.lag_ok) begin
            status <= ST_LAG_INVALID;
            state  <= S_DONE;
          end else begin
            quo   <= fuel_cur;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial_ge) begin
            rem <= trial_diff[CYL_W-1:0];
            quo <= {quo[TB-2:0], 1'b1};
          end else begin
            rem <= trial[CYL_W-1:0];
            quo <= {quo[TB-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(TIME_BITS - 1)) begin
            state <= S_GLOB;
          end
        end
        S_GLOB: begin
          acc   <= glob_prod;
          state <= S_LAG;
        end
        S_LAG: begin
          sat    <= sat | ovf | lag_sum[TB];
          pulse  <= lag_sum[TB] ? TIME_MAX : lag_sum[TB-1:0];
          status <= ST_OK;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!o_valid || rsp.ready) begin
            o_valid  <= 1'b1;
            o_pulse  <= pulse_wide[19:0];
            o_status <= status;
            o_cz     <= cz;
            o_sat    <= sat;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_cyl_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_NO_CYL) |->
      (rsp.pulse_us == '0 && !rsp.saturated && !rsp.crank_fuel_zero))
    else $error("missing cylinder result carries stray fields");

  a_err_zero_pulse: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_ZERO_FUEL || rsp.status == ST_LAG_INVALID)) |->
      (rsp.pulse_us == '0))
    else $error("error result carries a nonzero pulse");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (idx < j.nsteps))
    else $error("step index ran past the step list");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_pop) |=> (state != S_IDLE))
    else $error("popped a request without starting it");

endmodule

/* hw/rtl/injector_pulse_width_calc.sv */
// Top level of the injector pulse width calculator.
//
//  Channel  Direction  Transaction
//  req      in         one injection request (base fuel, coefficients, lag)
//  rsp      out        one pulse width with status and flags
//  APB      in         write or read of one configuration register
//
// In the back end each request runs through its scaling steps one at a time,
// the zero fuel and lag checks, the restoring divider, which produces one
// quotient bit per cycle, the global correction and the lag addition; zero
// fuel, invalid lag and missing cylinder results skip the divider and finish
// sooner.
// Reset is synchronous and active high; it restores the register defaults and
// empties the request queue and the result register.
// Requests enter a two-entry queue, so up to two may wait while one is worked
// on, and a finished result waits in the output register without blocking the
// next computation until it is also finished.
module injector_pulse_width_calc
  import ipw_pkg::*;
#(
  parameter int unsigned MAX_CYLINDERS  = 12,
  parameter int unsigned TIME_BITS      = 20,
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  ipw_in_if.sink             req,
  ipw_out_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Live cfg; user changes it only with no transaction in flight; unenforced.
  cfg_t cfg;

  // Front to queue and queue to back handshakes.
  logic push;
  job_t push_job;
  logic push_ready;
  logic pop_valid;
  job_t pop_job;
  logic pop;

  ipw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The front end classifies a request in the cycle it is accepted: it picks
  // the cranking or running coefficient list, inserts the launch gain and the
  // single point cylinder multiply where they apply, and works out the
  // injection count.
  ipw_front #(
    .MAX_CYLINDERS (MAX_CYLINDERS)
  ) u_front (
    .req     (req),
    .cfg     (cfg),
    .q_ready (push_ready),
    .push    (push),
    .job     (push_job)
  );

  ipw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop        (pop)
  );

  // The back end runs the step list one step at a time, tests for zero fuel
  // and a missing lag, divides by the injection count, applies the global
  // correction and adds the lag, saturating at every stage.
  ipw_back #(
    .TIME_BITS      (TIME_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_job   (pop_job),
    .q_pop   (pop),
    .rsp     (rsp)
  );

endmodule
